// ===== sv/olist_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// olist_pkg
// Shared constants, command codes and control types for the ordered list unit.
// -----------------------------------------------------------------------------
package olist_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 6;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 2'd0,
        CMD_DEL_KEY   = 2'd1,
        CMD_DEL_FIRST = 2'd2,
        CMD_DEL_LAST  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic compare;
        logic apply;
        logic report;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== sv/olist_cmd_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// olist_cmd_if
// Command channel: valid/ready handshake carrying a command and a key value.
// -----------------------------------------------------------------------------
interface olist_cmd_if;
    import olist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] key_value;

    modport source (output valid, output cmd, output key_value, input ready);
    modport sink   (input valid, input cmd, input key_value, output ready);

endinterface
`default_nettype wire

// ===== sv/olist_res_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// olist_res_if
// Result channel: valid/ready handshake carrying status, count and end values.
// -----------------------------------------------------------------------------
interface olist_res_if;
    import olist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     done_res;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;

    modport source (output valid, output done_res, output count,
                    output front_value, output back_value, input ready);
    modport sink   (input valid, input done_res, input count,
                    input front_value, input back_value, output ready);

endinterface
`default_nettype wire

// ===== sv/olist_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// olist_ctrl
// Sequencer: accept a command, compare, apply the update, then report.
// -----------------------------------------------------------------------------
module olist_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire olist_pkg::status_t status,
    output olist_pkg::ctrl_t       ctrl
);
    import olist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                // hold until the previous result has been taken
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.load     = in_valid;
            end
            ST_CMP:
            begin
                ctrl.compare = 1'b1;
            end
            ST_APPLY:
            begin
                ctrl.apply = 1'b1;
            end
            ST_REPORT:
            begin
                ctrl.report = status.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/olist_datapath.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// olist_datapath
// Row of list cells with parallel key compare, shift update and result register.
// -----------------------------------------------------------------------------
module olist_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [olist_pkg::CMD_W-1:0]      cmd,
    input  wire logic signed [olist_pkg::DATA_W-1:0] key_value,
    input  wire olist_pkg::ctrl_t                 ctrl,
    output olist_pkg::status_t                    status,
    olist_res_if.source                           res_ch
);
    import olist_pkg::*;

    logic [DATA_W-1:0] cells_reg [DEPTH];
    logic [DATA_W-1:0] cells_next [DEPTH];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] key_next;
    logic [DEPTH-1:0]  match_reg;
    logic [DEPTH-1:0]  match_next;
    logic              done_reg;
    logic              done_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_done_reg;
    logic              out_done_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;
    logic [DATA_W-1:0] out_front_reg;
    logic [DATA_W-1:0] out_front_next;
    logic [DATA_W-1:0] out_back_reg;
    logic [DATA_W-1:0] out_back_next;

    logic [DEPTH-1:0]  key_mask;
    logic [DEPTH-1:0]  shift_mask;
    logic [IDX_W-1:0]  back_idx;
    logic              do_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg     <= cells_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        match_reg     <= match_next;
        done_reg      <= done_next;
        out_done_reg  <= out_done_next;
        out_count_reg <= out_count_next;
        out_front_reg <= out_front_next;
        out_back_reg  <= out_back_next;
    end

    // cells at and above the first match take their upper neighbor
    assign key_mask   = match_reg | (~match_reg + DEPTH'(1));
    assign shift_mask = (cmd_reg == CMD_DEL_FIRST) ? '1 : key_mask;
    assign back_idx   = IDX_W'(occ_reg - OCC_W'(1));

    always_comb
    begin
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        match_next = match_reg;
        cells_next = cells_reg;
        occ_next   = occ_reg;
        done_next  = done_reg;
        do_shift   = 1'b0;

        if (ctrl.load)
        begin
            cmd_next = cmd_t'(cmd);
            key_next = key_value;
        end

        if (ctrl.compare)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                match_next[i] = (OCC_W'(i) < occ_reg) && (cells_reg[i] == key_reg);
            end
        end

        if (ctrl.apply)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (occ_reg < OCC_W'(DEPTH))
                    begin
                        cells_next[0] = key_reg;
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            cells_next[i] = cells_reg[i-1];
                        end
                        occ_next  = occ_reg + OCC_W'(1);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b0;
                    end
                end
                CMD_DEL_KEY:
                begin
                    do_shift  = |match_reg;
                    done_next = |match_reg;
                end
                CMD_DEL_FIRST:
                begin
                    do_shift  = (occ_reg != '0);
                    done_next = (occ_reg != '0);
                end
                CMD_DEL_LAST:
                begin
                    done_next = (occ_reg != '0);
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase

            if (do_shift)
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    if (shift_mask[i])
                    begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
            end

            if (cmd_reg != CMD_INSERT && done_next)
            begin
                occ_next = occ_reg - OCC_W'(1);
            end
        end
    end

    assign status.out_free = !out_valid_reg || res_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_done_next  = out_done_reg;
        out_count_next = out_count_reg;
        out_front_next = out_front_reg;
        out_back_next  = out_back_reg;

        if (ctrl.report)
        begin
            out_valid_next = 1'b1;
            out_done_next  = done_reg;
            out_count_next = COUNT_W'(occ_reg);
            if (occ_reg != '0)
            begin
                out_front_next = cells_reg[0];
                out_back_next  = cells_reg[back_idx];
            end
            else
            begin
                out_front_next = '0;
                out_back_next  = '0;
            end
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.done_res    = out_done_reg;
    assign res_ch.count       = out_count_reg;
    assign res_ch.front_value = $signed(out_front_reg);
    assign res_ch.back_value  = $signed(out_back_reg);

endmodule
`default_nettype wire

// ===== sv/ordered_list_delete_by_key_unit.sv =====
`default_nettype none
// Sequence per command: accept, key compare across the cell row, shift update,
// result load; a new command is taken only after the result load, and a stalled
// result transaction holds the sequencer before the result load.
// Reset: asynchronous, clears the element count, the sequencer and the result
// valid flag; cell contents are not cleared and need no clearing pass.
// -----------------------------------------------------------------------------
// ordered_list_delete_by_key_unit
// Bounded ordered list with insert-front, delete-by-key and end deletions.
// -----------------------------------------------------------------------------
module ordered_list_delete_by_key_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    olist_cmd_if.sink   cmd_ch,
    olist_res_if.source res_ch
);
    import olist_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    assign cmd_ch.ready = ctrl.in_ready;

    olist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    olist_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch.cmd),
        .key_value (cmd_ch.key_value),
        .ctrl      (ctrl),
        .status    (status),
        .res_ch    (res_ch)
    );

`ifndef SYNTH
    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ch.valid && cmd_ch.ready) |=> !cmd_ch.ready)
        else $error("command accepted while another is in flight");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.report |-> (!res_ch.valid || res_ch.ready))
        else $error("pending result overwritten");

    a_single_step : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.compare, ctrl.apply, ctrl.report}))
        else $error("more than one sequencer step active");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> (res_ch.count <= COUNT_W'(DEPTH)))
        else $error("reported count exceeds capacity");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_ordered_list_delete_by_key_unit.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// tb_ordered_list_delete_by_key_unit
// Self-checking bench for the ordered list unit. A command backlog feeds a
// valid/ready driver. Each accepted command runs through a local list model
// that yields the expected report. A monitor checks every result transaction
// against the oldest awaited report. A directed opening covers empty and
// extreme cases. Random fill, drain and mixed runs follow under three idle
// profiles, with one long result back-pressure stretch.
// -----------------------------------------------------------------------------
module tb_ordered_list_delete_by_key_unit;
    import olist_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int LONG_STALL     = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_SETTLE     = 8;
    localparam int MAX_REPORTED   = 10;
    localparam int POOL_CAP       = 40;

    typedef struct {
        cmd_t        op;
        logic [31:0] key;
    } list_cmd_t;

    typedef struct packed {
        logic                     done_res;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } list_report_t;

    logic clk = 1'b0;
    logic rst_n;

    olist_cmd_if cmd_if ();
    olist_res_if res_if ();

    ordered_list_delete_by_key_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_if),
        .res_ch (res_if)
    );

    // list model state
    logic [DATA_W-1:0] model_cells [DEPTH];
    int                model_len = 0;

    list_cmd_t    cmd_backlog [$];
    list_report_t awaited_reports [$];
    logic [31:0]  key_pool [$];

    int   tx_idle_pct = 15;
    int   rx_idle_pct = 73;
    int   stall_req   = 0;
    int   stall_ack   = 0;
    int   stall_left  = 0;
    logic cmd_taken   = 1'b0;

    int error_count    = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int refused_insert = 0;
    int key_misses     = 0;
    int empty_deletes  = 0;
    int peak_count     = 0;
    int idle_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Shift-array list: index 0 is the front.
    function automatic list_report_t apply_list_cmd(input cmd_t op, input logic [31:0] v);
        list_report_t r;
        int           hit;
        r.done_res = 1'b0;
        hit = -1;
        case (op)
            CMD_INSERT:
                if (model_len < DEPTH)
                begin
                    for (int i = model_len; i > 0; i--)
                        model_cells[i] = model_cells[i-1];
                    model_cells[0] = v;
                    model_len++;
                    r.done_res = 1'b1;
                end
            CMD_DEL_KEY:
            begin
                for (int i = 0; i < model_len && hit < 0; i++)
                    if (model_cells[i] == v)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < model_len; i++)
                        model_cells[i] = model_cells[i+1];
                    model_len--;
                    r.done_res = 1'b1;
                end
            end
            CMD_DEL_FIRST:
                if (model_len > 0)
                begin
                    for (int i = 0; i + 1 < model_len; i++)
                        model_cells[i] = model_cells[i+1];
                    model_len--;
                    r.done_res = 1'b1;
                end
            default:
                if (model_len > 0)
                begin
                    model_len--;
                    r.done_res = 1'b1;
                end
        endcase
        r.count = model_len[COUNT_W-1:0];
        if (model_len > 0)
        begin
            r.front_value = model_cells[0];
            r.back_value  = model_cells[model_len-1];
        end
        else
        begin
            r.front_value = '0;
            r.back_value  = '0;
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic push_cmd(input cmd_t op, input logic [31:0] key);
        list_cmd_t c;
        c.op  = op;
        c.key = key;
        cmd_backlog.push_back(c);
    endtask

    // Keys for deletes come mostly from recently inserted values so they hit.
    function automatic list_cmd_t make_random(input int insert_pct, input int key_pct);
        list_cmd_t c;
        int        roll;
        int        pick;
        roll  = $urandom_range(99);
        c.key = $urandom;
        if (roll < insert_pct)
        begin
            c.op = CMD_INSERT;
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                case ($urandom_range(3))
                    0: c.key = 32'h7FFF_FFFF;
                    1: c.key = 32'h8000_0000;
                    2: c.key = 32'h0000_0000;
                    default: c.key = 32'hFFFF_FFFF;
                endcase
            end
            else if (pick < 35)
                c.key = $urandom_range(7);
            key_pool.push_back(c.key);
            if (key_pool.size() > POOL_CAP)
                void'(key_pool.pop_front());
        end
        else if (roll < insert_pct + key_pct)
        begin
            c.op = CMD_DEL_KEY;
            if (key_pool.size() > 0 && $urandom_range(99) < 75)
                c.key = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        else
            c.op = $urandom_range(1) ? CMD_DEL_FIRST : CMD_DEL_LAST;
        return c;
    endfunction

    task automatic gen_run(input int n, input int insert_pct, input int key_pct);
        for (int i = 0; i < n; i++)
            cmd_backlog.push_back(make_random(insert_pct, key_pct));
    endtask

    // Blocks until the backlog is sent and every awaited report is back.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || awaited_reports.size() != 0 || cmd_if.valid)
            @(negedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit long_stall);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        gen_run(60, 85, 8);
        gen_run(60, 10, 50);
        gen_run(50, 40, 30);
        if (long_stall)
            stall_req++;
        wait_drained();
    endtask

    // command driver
    always @(negedge clk)
    begin : drive_cmd
        list_cmd_t c;
        if (!rst_n)
            cmd_if.valid <= 1'b0;
        else if (cmd_if.valid && !cmd_taken)
            ; // hold the offered transaction
        else if (cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct)
        begin
            c = cmd_backlog.pop_front();
            cmd_if.valid     <= 1'b1;
            cmd_if.cmd       <= c.op;
            cmd_if.key_value <= c.key;
        end
        else
            cmd_if.valid <= 1'b0;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (stall_ack != stall_req)
        begin
            stall_ack    <= stall_req;
            stall_left   <= LONG_STALL;
            res_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // predictor and monitor
    always @(posedge clk)
    begin : score
        list_report_t want;
        list_report_t got;
        cmd_taken <= cmd_if.valid && cmd_if.ready;
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                want = apply_list_cmd(cmd_t'(cmd_if.cmd), cmd_if.key_value);
                awaited_reports.push_back(want);
                cmds_accepted++;
                if (model_len > peak_count)
                    peak_count = model_len;
                if (!want.done_res)
                begin
                    if (cmd_if.cmd == CMD_INSERT)
                        refused_insert++;
                    else if (cmd_if.cmd == CMD_DEL_KEY)
                        key_misses++;
                    else
                        empty_deletes++;
                end
            end
            if (res_if.valid && res_if.ready)
            begin
                got.done_res    = res_if.done_res;
                got.count       = res_if.count;
                got.front_value = res_if.front_value;
                got.back_value  = res_if.back_value;
                results_seen++;
                if (awaited_reports.size() == 0)
                    flag_error("result transaction with no command outstanding");
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.done_res !== want.done_res || got.count !== want.count ||
                        got.front_value !== want.front_value ||
                        got.back_value !== want.back_value)
                        flag_error({
                            $sformatf("result %0d: exp done=%0b count=%0d front=%0d back=%0d",
                                results_seen, want.done_res, want.count,
                                $signed(want.front_value), $signed(want.back_value)),
                            $sformatf(", got done=%0b count=%0d front=%0d back=%0d",
                                got.done_res, got.count,
                                $signed(got.front_value), $signed(got.back_value))});
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = CMD_INSERT;
        cmd_if.key_value = '0;
        res_if.ready     = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // empty list, extremes, duplicates, absent keys, all-ones key on an empty list
        push_cmd(CMD_DEL_FIRST, 32'h0000_0000);
        push_cmd(CMD_DEL_LAST,  32'hFFFF_FFFF);
        push_cmd(CMD_DEL_KEY,   32'h0000_0000);
        push_cmd(CMD_INSERT,    32'h7FFF_FFFF);
        push_cmd(CMD_INSERT,    32'h8000_0000);
        push_cmd(CMD_INSERT,    32'h0000_0000);
        push_cmd(CMD_INSERT,    32'hFFFF_FFFF);
        push_cmd(CMD_INSERT,    32'h0000_0001);
        push_cmd(CMD_INSERT,    32'h0000_0005);
        push_cmd(CMD_INSERT,    32'h0000_0005);
        push_cmd(CMD_DEL_KEY,   32'h0000_3039);
        push_cmd(CMD_DEL_KEY,   32'h8000_0001);
        push_cmd(CMD_DEL_KEY,   32'h0000_0005);
        push_cmd(CMD_DEL_KEY,   32'h8000_0000);
        push_cmd(CMD_DEL_KEY,   32'h7FFF_FFFF);
        push_cmd(CMD_DEL_FIRST, 32'h7FFF_FFFF);
        push_cmd(CMD_DEL_LAST,  32'h8000_0000);
        push_cmd(CMD_DEL_KEY,   32'h0000_0001);
        push_cmd(CMD_DEL_LAST,  32'hFFFF_FFFF);
        push_cmd(CMD_DEL_KEY,   32'hFFFF_FFFF);
        push_cmd(CMD_INSERT,    32'hA5A5_A5A5);
        push_cmd(CMD_DEL_FIRST, 32'h5A5A_5A5A);
        wait_drained();

        run_phase(15, 73, 1'b0);
        run_phase(73, 15, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (END_SETTLE) @(negedge clk);
        if (awaited_reports.size() != 0)
            flag_error($sformatf("%0d reports never arrived", awaited_reports.size()));

        $display("Ran %0d commands, checked %0d results, peak occupancy %0d of %0d",
                 cmds_accepted, results_seen, peak_count, DEPTH);
        $display("No-op cases: %0d full-list inserts, %0d key misses, %0d empty deletes",
                 refused_insert, key_misses, empty_deletes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
